FILE: rtl/b64e_pkg.sv
// b64e_pkg: shared types, constants and the alphabet lookup of the base64 encoder
// no dependencies

package b64e_pkg;

  // number of complete groups buffered between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // one 24-bit group waiting to be emitted as four characters
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  pad_count;
    logic        is_end;
  } group_t;

  // queue status seen by the front and the top level
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } queue_status_t;

  // standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] char_of(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      char_of = 8'(8'd65 + wide);
    end else if (idx < 6'd52) begin
      char_of = 8'(8'd71 + wide);       // 'a' - 26
    end else if (idx < 6'd62) begin
      char_of = 8'(wide - 8'd4);        // '0' - 52
    end else if (idx == 6'd62) begin
      char_of = 8'h2B;
    end else begin
      char_of = 8'h2F;
    end
  endfunction

endpackage

FILE: rtl/b64e_if.sv
// b64e_byte_if and b64e_char_if: valid/ready channels of the base64 encoder
// no dependencies

interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_char;
  logic       last_char;

  modport source (output valid, output code_char, output last_char, input ready);
  modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

FILE: rtl/base64_encoder_unit.sv
// base64_encoder_unit: streaming standard base64 encoder, top level
// depends on b64e_pkg, b64e_if, b64e_front, b64e_queue and b64e_back
//
// usage
//   in_byte_i takes one message byte per transaction with end_of_message on
//   the final byte. out_char_o gives one ascii character per transaction,
//   last_char high on the final character of the message.
//   every third byte, or a byte with end_of_message, yields four characters;
//   a short final group is zero filled and padded with one or two '='.
//   the byte that closes a group pushes it into the group queue, and its
//   characters leave from the queue head, one character per transaction.
//   throughput: one byte per cycle while the group queue has room; the
//   sustained rate is set by the output channel at one character per cycle
//   while the receiver is ready. the two-entry group queue lets up to two
//   finished groups wait while bytes keep arriving.
//   when the receiver stalls the current character holds and the queue
//   fills; in_byte_i.ready drops only when both entries are taken.
//   reset (rst_ni low, asynchronous) empties the queue and clears any
//   partial group, so the next byte starts a new message.

module base64_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64e_byte_if.sink   in_byte_i,
  b64e_char_if.source out_char_o
);
  import b64e_pkg::*;

  logic          push, pop;
  group_t        push_group, head;
  queue_status_t q_status;

  // byte grouping
  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_byte_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_group_o (push_group)
  );

  // group queue
  b64e_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // character output
  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (~q_status.empty),
    .pop_o        (pop),
    .out_char_o   (out_char_o)
  );

`ifndef SYNTH
  // occupancy never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= CNT_W'(QUEUE_DEPTH))
    else $error("group queue over-filled");

  // a message end always leaves a group in the queue
  a_eom_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_byte_i.valid && in_byte_i.ready && in_byte_i.end_of_message)
    |=> !q_status.empty)
    else $error("message end did not queue a group");

  // padding that is not final is followed by more padding
  a_pad_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_char_o.valid && out_char_o.ready && out_char_o.code_char == PAD_CHAR
     && !out_char_o.last_char)
    |=> (out_char_o.valid && out_char_o.code_char == PAD_CHAR))
    else $error("padding run broken");

  // padding only ever ends a message
  a_pad_in_last_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_char_o.valid && out_char_o.code_char == PAD_CHAR) |-> head.is_end)
    else $error("padding outside the final group");
`endif

endmodule

FILE: rtl/b64e_front.sv
// b64e_front: collects message bytes into 3-byte groups and pushes finished groups
// depends on b64e_pkg and b64e_byte_if

module b64e_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  b64e_byte_if.sink              in_byte_i,
  input  b64e_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output b64e_pkg::group_t       push_group_o
);
  import b64e_pkg::*;

  logic [15:0] pend_q, pend_d;
  logic [1:0]  fill_q, fill_d;
  logic        accept;

  // a byte is taken whenever the queue has room for a group
  assign in_byte_i.ready = ~q_status_i.full;
  assign accept          = in_byte_i.valid & in_byte_i.ready;

  // grouping and padding decision
  always_comb begin
    pend_d       = pend_q;
    fill_d       = fill_q;
    push_o       = 1'b0;
    push_group_o = '0;
    if (accept) begin
      if (fill_q >= 2'd2) begin
        push_o                 = 1'b1;
        push_group_o.bits      = {pend_q, in_byte_i.data_byte};
        push_group_o.pad_count = 2'd0;
        push_group_o.is_end    = in_byte_i.end_of_message;
        pend_d                 = '0;
        fill_d                 = 2'd0;
      end else if (in_byte_i.end_of_message) begin
        push_o              = 1'b1;
        push_group_o.is_end = 1'b1;
        if (fill_q == 2'd0) begin
          push_group_o.bits      = {in_byte_i.data_byte, 16'h0000};
          push_group_o.pad_count = 2'd2;
        end else begin
          push_group_o.bits      = {pend_q[15:8], in_byte_i.data_byte, 8'h00};
          push_group_o.pad_count = 2'd1;
        end
        pend_d = '0;
        fill_d = 2'd0;
      end else if (fill_q == 2'd0) begin
        pend_d = {in_byte_i.data_byte, 8'h00};
        fill_d = 2'd1;
      end else begin
        pend_d = {pend_q[15:8], in_byte_i.data_byte};
        fill_d = 2'd2;
      end
    end
  end

  // pending bytes and group fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      fill_q <= '0;
    end else begin
      pend_q <= pend_d;
      fill_q <= fill_d;
    end
  end

endmodule

FILE: rtl/b64e_queue.sv
// b64e_queue: short group queue between the front and the back
// depends on b64e_pkg

module b64e_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  b64e_pkg::group_t        push_group_i,
  input  logic                    pop_i,
  output b64e_pkg::group_t        head_o,
  output b64e_pkg::queue_status_t status_o
);
  import b64e_pkg::*;

  group_t           entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      next_ptr = '0;
    end else begin
      next_ptr = p + 1'b1;
    end
  endfunction

  assign status_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;
  assign head_o         = entry_q[rd_ptr_q];

  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_group_i;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/b64e_back.sv
// b64e_back: turns the head group into four characters, one per transaction
// depends on b64e_pkg and b64e_char_if

module b64e_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  b64e_pkg::group_t head_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  b64e_char_if.source      out_char_o
);
  import b64e_pkg::*;

  logic [1:0] slot_q, slot_d;
  logic [5:0] idx;
  logic       accept;

  // six-bit slice for the current slot, most significant first
  always_comb begin
    case (slot_q)
      2'd0:    idx = head_i.bits[23:18];
      2'd1:    idx = head_i.bits[17:12];
      2'd2:    idx = head_i.bits[11:6];
      default: idx = head_i.bits[5:0];
    endcase
  end

  // character, padding and end flag
  assign out_char_o.valid     = head_valid_i;
  assign out_char_o.code_char = ({1'b0, slot_q} >= (3'd4 - {1'b0, head_i.pad_count}))
                                ? PAD_CHAR : char_of(idx);
  assign out_char_o.last_char = (slot_q == 2'd3) & head_i.is_end;

  assign accept = out_char_o.valid & out_char_o.ready;
  assign pop_o  = accept & (slot_q == 2'd3);
  assign slot_d = accept ? slot_q + 2'd1 : slot_q;

  // slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for the streaming base64 encoder base64_encoder_unit
// depends on b64e_pkg, b64e_if and the encoder rtl; predicts every character
// from its own group model and checks each output transaction in order

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  // one predicted output character
  typedef struct packed {
    logic [7:0] code_char;
    logic       last_char;
  } enc_char_t;

  logic clk_i;
  logic rst_ni;

  b64e_byte_if byte_if ();
  b64e_char_if char_if ();

  base64_encoder_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (byte_if),
    .out_char_o (char_if)
  );

  string code_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // predictor state: bytes held of the open group
  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [1:0] held_count;

  enc_char_t expected_chars[$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned bytes_sent;
  int unsigned messages_sent;
  int unsigned chars_checked;
  int unsigned error_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // safety net against a hung handshake
  initial begin
    #400us;
    $display("%0t: timeout, %0d characters still expected", $time, expected_chars.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // split one 24-bit group into four characters, the last pad_count as '='
  task automatic predict_group(input logic [23:0] group_bits, input int pad_count,
                               input logic is_end);
    enc_char_t  c;
    logic [5:0] idx;
    for (int k = 0; k < 4; k++) begin
      idx = group_bits[23 - 6 * k -: 6];
      c.code_char = (k >= 4 - pad_count) ? PAD_CHAR : code_alphabet[idx];
      c.last_char = (k == 3) ? is_end : 1'b0;
      expected_chars.push_back(c);
    end
  endtask

  // advance the group model by one accepted byte
  task automatic predict_byte(input logic [7:0] data, input logic eom);
    if (held_count == 2'd2) begin
      predict_group({held_first, held_second, data}, 0, eom);
      held_count = 2'd0;
    end else if (held_count == 2'd0) begin
      held_first = data;
      held_count = 2'd1;
      if (eom) begin
        predict_group({data, 16'h0000}, 2, 1'b1);
        held_count = 2'd0;
      end
    end else begin
      held_second = data;
      held_count  = 2'd2;
      if (eom) begin
        predict_group({held_first, data, 8'h00}, 1, 1'b1);
        held_count = 2'd0;
      end
    end
  endtask

  // monitor: predict on accepted bytes first, then check accepted characters
  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        predict_byte(byte_if.data_byte, byte_if.end_of_message);
      end
      if (char_if.valid && char_if.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character, expected none, actual %h last %b",
                   $time, char_if.code_char, char_if.last_char);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (char_if.code_char !== want.code_char) begin
            $display("%0t: code_char mismatch, expected %h, actual %h",
                     $time, want.code_char, char_if.code_char);
            error_count++;
          end
          if (char_if.last_char !== want.last_char) begin
            $display("%0t: last_char mismatch, expected %b, actual %b",
                     $time, want.last_char, char_if.last_char);
            error_count++;
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      char_if.ready = ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // send one byte, with random idle cycles first, and wait for the transaction
  task automatic send_byte(input logic [7:0] data, input logic eom);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_if.valid          = 1'b0;
      byte_if.data_byte      = 8'($urandom);
      byte_if.end_of_message = 1'($urandom);
      @(negedge clk_i);
    end
    byte_if.valid          = 1'b1;
    byte_if.data_byte      = data;
    byte_if.end_of_message = eom;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
    if (eom) messages_sent++;
  endtask

  // messages ending on a full group, no padding
  task automatic test_full_group_end();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // message ending with one byte held: two characters then "=="
  task automatic test_one_byte_tail();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b1);
  endtask

  // message ending with two bytes held: three characters then "="
  task automatic test_two_byte_tail();
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // groups followed by a short tail, reaching both ends of the alphabet
  task automatic test_groups_then_tail();
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // random messages, mostly short with some long ones and edge bytes
  task automatic test_random_messages(input int unsigned src_pct, input int unsigned snk_pct,
                                      input int unsigned n_bytes);
    int unsigned target;
    int unsigned msg_len;
    logic [7:0]  data;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
      for (int i = 0; i < msg_len; i++) begin
        case ($urandom_range(0, 9))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom);
        endcase
        send_byte(data, (i == msg_len - 1));
      end
    end
  endtask

  // main sequence
  initial begin
    int unsigned guard;
    rst_ni                 = 1'b0;
    byte_if.valid          = 1'b0;
    byte_if.data_byte      = 8'h00;
    byte_if.end_of_message = 1'b0;
    char_if.ready          = 1'b0;
    held_first             = 8'h00;
    held_second            = 8'h00;
    held_count             = 2'd0;
    src_idle_pct           = 36;
    snk_idle_pct           = 59;
    bytes_sent             = 0;
    messages_sent          = 0;
    chars_checked          = 0;
    error_count            = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_full_group_end();
    test_one_byte_tail();
    test_two_byte_tail();
    test_groups_then_tail();
    test_random_messages(36, 59, 32);
    test_random_messages(59, 36, 32);
    test_random_messages(0, 0, 32);

    @(negedge clk_i);
    byte_if.valid = 1'b0;

    // drain, then allow a few cycles for anything stray
    guard = 0;
    while (expected_chars.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);

    if (expected_chars.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, expected_chars.size());
      error_count++;
    end
    $display("encoded %0d bytes in %0d messages, checked %0d characters", bytes_sent,
             messages_sent, chars_checked);
    $display("three back-pressure phases, tails of zero, one and two bytes, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
